[rtl/assert_macros.svh]
// Assertion helpers for the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while reset is low.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, checked while reset is low.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[rtl/tw_pkg.sv]
// ----------------------------------------------------------------------------
// tw_pkg
// Types and constants of the transmit window with retransmit queue.
// ----------------------------------------------------------------------------
package tw_pkg;

   localparam int SLOTS_DEFAULT = 256;
   localparam int SEQ_W         = 32;
   localparam int HND_W         = 16;
   localparam int LEN_W         = 16;
   localparam int STAMP_W       = 48;
   localparam int BYTES_W       = 24;
   localparam int SEC_W         = 12;
   localparam int THR_W         = 32;
   localparam logic [THR_W-1:0] US_PER_SEC = 32'd1000000;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_NAK    = 2'd2,
      CMD_POP    = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK             = 3'd0,
      ST_NOT_IN_WINDOW  = 3'd1,
      ST_ALREADY_QUEUED = 3'd2,
      ST_WINDOW_FULL    = 3'd3,
      ST_QUEUE_EMPTY    = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_ADD_CHECK,
      BK_ADD_AGE,
      BK_ADD_DECIDE,
      BK_ADD_WRITE,
      BK_FIND_CHECK,
      BK_FIND_DONE,
      BK_POP_CHECK,
      BK_POP_READ,
      BK_UNLINK_READ,
      BK_UNLINK_LINK,
      BK_UNLINK_HEAD,
      BK_RESPOND
   } bk_state_type;

   typedef struct packed {
      cmd_type              cmd;
      logic [SEQ_W-1:0]     seq;
      logic [HND_W-1:0]     hnd;
      logic [LEN_W-1:0]     len;
      logic [STAMP_W-1:0]   now;
   } item_type;

   typedef struct packed {
      logic [HND_W-1:0]     hnd;
      logic [LEN_W-1:0]     len;
      logic [STAMP_W-1:0]   stamp;
   } slot_type;

   typedef struct packed {
      status_type           status;
      logic [SEQ_W-1:0]     result_sequence;
      logic [HND_W-1:0]     result_handle;
      logic [LEN_W-1:0]     result_length;
      logic                 evicted_valid;
      logic [HND_W-1:0]     evicted_handle;
      logic                 retx_pending;
      logic [SEQ_W-1:0]     retx_head_seq;
      logic [HND_W-1:0]     retx_head_handle;
      logic [SEQ_W-1:0]     lead_seq;
      logic [SEQ_W-1:0]     trail_seq;
      logic [BYTES_W-1:0]   window_bytes;
   } rsp_type;

endpackage

[rtl/tw_ram.sv]
// ----------------------------------------------------------------------------
// tw_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/tw_front.sv]
// ----------------------------------------------------------------------------
// tw_front
// Accepts command transactions, decodes them and holds them in a two-entry
// queue for the execution side.
// ----------------------------------------------------------------------------
module tw_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_command,
   input  logic [tw_pkg::SEQ_W-1:0] req_sequence_req,
   input  logic [tw_pkg::HND_W-1:0] req_packet_handle,
   input  logic [tw_pkg::LEN_W-1:0] req_packet_length,
   input  logic [tw_pkg::STAMP_W-1:0] req_now_us,
   output logic                     item_valid,
   output tw_pkg::item_type         item,
   input  logic                     item_pop
);

   tw_pkg::item_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push;
   tw_pkg::item_type decoded;

   assign busy       = (count_ff == 2'd2);
   assign push       = start && !busy;
   assign item_valid = (count_ff != 2'd0);
   assign item       = entry_ff[rd_ptr_ff];

   always_comb begin
      decoded.cmd = tw_pkg::cmd_type'(req_command);
      decoded.seq = req_sequence_req;
      decoded.hnd = req_packet_handle;
      decoded.len = req_packet_length;
      decoded.now = req_now_us;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ (item_pop && item_valid);
      count_in  = count_ff + {1'b0, push} - {1'b0, item_pop && item_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

[rtl/tw_back.sv]
// ----------------------------------------------------------------------------
// tw_back
// Executes window commands: ring storage, eviction, NAK queue links and the
// registered result.
// ----------------------------------------------------------------------------
module tw_back #(
   parameter int SLOTS = tw_pkg::SLOTS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [tw_pkg::SEC_W-1:0] csr_wr_data,
   input  logic                     item_valid,
   input  tw_pkg::item_type         item,
   output logic                     item_pop,
   output logic                     rsp_valid,
   output tw_pkg::rsp_type          rsp
);

   localparam int IDX_W = $clog2(SLOTS);

   tw_pkg::bk_state_type state_ff, state_in;
   tw_pkg::item_type     cur_ff, cur_in;

   logic [tw_pkg::SEQ_W-1:0]   lead_ff, lead_in, trail_ff, trail_in;
   logic [tw_pkg::BYTES_W-1:0] bytes_ff, bytes_in;
   logic [IDX_W-1:0]           oldest_ff, oldest_in, newest_ff, newest_in;
   logic                       nonempty_ff, nonempty_in;
   logic [tw_pkg::HND_W-1:0]   head_hnd_ff, head_hnd_in;
   logic [tw_pkg::SEC_W-1:0]   sec_ff;
   logic [tw_pkg::THR_W-1:0]   thr_ff;
   logic                       ret_add_ff, ret_add_in;
   logic [IDX_W-1:0]           unl_idx_ff, unl_idx_in;
   logic [tw_pkg::STAMP_W-1:0] diff_ff, diff_in;
   logic                       evq_ff, evq_in;
   logic [tw_pkg::LEN_W-1:0]   evlen_ff, evlen_in;

   tw_pkg::status_type         status_ff, status_in;
   logic [tw_pkg::SEQ_W-1:0]   rseq_ff, rseq_in;
   logic [tw_pkg::HND_W-1:0]   rhnd_ff, rhnd_in;
   logic [tw_pkg::LEN_W-1:0]   rlen_ff, rlen_in;
   logic                       evv_ff, evv_in;
   logic [tw_pkg::HND_W-1:0]   evh_ff, evh_in;

   tw_pkg::rsp_type            out_ff, out_in;
   logic                       valid_ff, valid_in;

   // RAM ports.
   logic             slot_we, qbit_we, qbit_wd, nxt_we, prv_we;
   logic [IDX_W-1:0] slot_wa, qbit_wa, nxt_wa, nxt_wd, prv_wa, prv_wd;
   logic [IDX_W-1:0] slot_ra, link_ra;
   tw_pkg::slot_type slot_wd, slot_rd;
   logic             qbit_rd;
   logic [IDX_W-1:0] nxt_rd, prv_rd;

   // Shared conditions.
   logic [tw_pkg::SEQ_W-1:0] held;
   logic                     full, inwin, evict_ok, is_old, is_new;
   logic [IDX_W-1:0]         trail_idx, seq_idx, lead_idx_next, head_off;
   logic [tw_pkg::SEC_W:0]   sec_p1;
   logic [tw_pkg::THR_W-1:0] thr_in;

   assign held          = lead_ff + 32'd1 - trail_ff;
   assign full          = (held == 32'(SLOTS));
   assign inwin         = ((cur_ff.seq - trail_ff) < held);
   assign evict_ok      = (sec_ff == '0) || (diff_ff >= tw_pkg::STAMP_W'(thr_ff));
   assign is_old        = (unl_idx_ff == oldest_ff);
   assign is_new        = (unl_idx_ff == newest_ff);
   assign trail_idx     = trail_ff[IDX_W-1:0];
   assign seq_idx       = cur_ff.seq[IDX_W-1:0];
   assign lead_idx_next = lead_ff[IDX_W-1:0] + IDX_W'(1);
   assign head_off      = oldest_ff - trail_idx;

   // Eviction needs age > seconds (any age when seconds is zero), i.e. elapsed microseconds >= (seconds + 1) * 1e6.
   assign sec_p1 = {1'b0, csr_wr_data} + 13'd1;
   assign thr_in = tw_pkg::THR_W'(tw_pkg::THR_W'(sec_p1) * tw_pkg::US_PER_SEC);

   tw_ram #(.WIDTH($bits(tw_pkg::slot_type)), .DEPTH(SLOTS)) u_slot_ram (
      .clock(clock), .wr_en(slot_we), .wr_addr(slot_wa), .wr_data(slot_wd),
      .rd_addr(slot_ra), .rd_data(slot_rd));
   tw_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_qbit_ram (
      .clock(clock), .wr_en(qbit_we), .wr_addr(qbit_wa), .wr_data(qbit_wd),
      .rd_addr(slot_ra), .rd_data(qbit_rd));
   tw_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_next_ram (
      .clock(clock), .wr_en(nxt_we), .wr_addr(nxt_wa), .wr_data(nxt_wd),
      .rd_addr(link_ra), .rd_data(nxt_rd));
   tw_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_prev_ram (
      .clock(clock), .wr_en(prv_we), .wr_addr(prv_wa), .wr_data(prv_wd),
      .rd_addr(link_ra), .rd_data(prv_rd));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tw_pkg::BK_IDLE: begin
            if (item_valid) begin
               unique case (item.cmd)
                  tw_pkg::CMD_ADD: state_in = tw_pkg::BK_ADD_CHECK;
                  tw_pkg::CMD_POP: state_in = tw_pkg::BK_POP_CHECK;
                  default:         state_in = tw_pkg::BK_FIND_CHECK;
               endcase
            end
         end
         tw_pkg::BK_ADD_CHECK:
            state_in = full ? tw_pkg::BK_ADD_AGE : tw_pkg::BK_ADD_WRITE;
         tw_pkg::BK_ADD_AGE: state_in = tw_pkg::BK_ADD_DECIDE;
         tw_pkg::BK_ADD_DECIDE: begin
            if (!evict_ok) begin
               state_in = tw_pkg::BK_RESPOND;
            end else if (evq_ff) begin
               state_in = tw_pkg::BK_UNLINK_READ;
            end else begin
               state_in = tw_pkg::BK_ADD_WRITE;
            end
         end
         tw_pkg::BK_ADD_WRITE: state_in = tw_pkg::BK_RESPOND;
         tw_pkg::BK_FIND_CHECK:
            state_in = inwin ? tw_pkg::BK_FIND_DONE : tw_pkg::BK_RESPOND;
         tw_pkg::BK_FIND_DONE: state_in = tw_pkg::BK_RESPOND;
         tw_pkg::BK_POP_CHECK:
            state_in = nonempty_ff ? tw_pkg::BK_POP_READ : tw_pkg::BK_RESPOND;
         tw_pkg::BK_POP_READ: state_in = tw_pkg::BK_UNLINK_READ;
         tw_pkg::BK_UNLINK_READ: state_in = tw_pkg::BK_UNLINK_LINK;
         tw_pkg::BK_UNLINK_LINK: begin
            if (is_old && !is_new) begin
               state_in = tw_pkg::BK_UNLINK_HEAD;
            end else begin
               state_in = ret_add_ff ? tw_pkg::BK_ADD_WRITE : tw_pkg::BK_RESPOND;
            end
         end
         tw_pkg::BK_UNLINK_HEAD:
            state_in = ret_add_ff ? tw_pkg::BK_ADD_WRITE : tw_pkg::BK_RESPOND;
         tw_pkg::BK_RESPOND: state_in = tw_pkg::BK_IDLE;
         default: state_in = tw_pkg::BK_IDLE;
      endcase
   end

   // Read addresses.
   always_comb begin
      unique case (state_ff)
         tw_pkg::BK_FIND_CHECK:  slot_ra = seq_idx;
         tw_pkg::BK_POP_CHECK:   slot_ra = oldest_ff;
         tw_pkg::BK_UNLINK_LINK: slot_ra = nxt_rd;
         default:                slot_ra = trail_idx;
      endcase
      link_ra = unl_idx_ff;
   end

   // Datapath and RAM writes.
   always_comb begin
      item_pop    = 1'b0;
      cur_in      = cur_ff;
      lead_in     = lead_ff;
      trail_in    = trail_ff;
      bytes_in    = bytes_ff;
      oldest_in   = oldest_ff;
      newest_in   = newest_ff;
      nonempty_in = nonempty_ff;
      head_hnd_in = head_hnd_ff;
      ret_add_in  = ret_add_ff;
      unl_idx_in  = unl_idx_ff;
      diff_in     = diff_ff;
      evq_in      = evq_ff;
      evlen_in    = evlen_ff;
      status_in   = status_ff;
      rseq_in     = rseq_ff;
      rhnd_in     = rhnd_ff;
      rlen_in     = rlen_ff;
      evv_in      = evv_ff;
      evh_in      = evh_ff;
      out_in      = out_ff;
      valid_in    = 1'b0;
      slot_we     = 1'b0;
      slot_wa     = lead_idx_next;
      slot_wd     = '{hnd: cur_ff.hnd, len: cur_ff.len, stamp: cur_ff.now};
      qbit_we     = 1'b0;
      qbit_wa     = unl_idx_ff;
      qbit_wd     = 1'b0;
      nxt_we      = 1'b0;
      nxt_wa      = prv_rd;
      nxt_wd      = nxt_rd;
      prv_we      = 1'b0;
      prv_wa      = nxt_rd;
      prv_wd      = prv_rd;

      unique case (state_ff)
         tw_pkg::BK_IDLE: begin
            if (item_valid) begin
               item_pop  = 1'b1;
               cur_in    = item;
               status_in = tw_pkg::ST_OK;
               rseq_in   = '0;
               rhnd_in   = '0;
               rlen_in   = '0;
               evv_in    = 1'b0;
               evh_in    = '0;
            end
         end
         tw_pkg::BK_ADD_CHECK: ;
         tw_pkg::BK_ADD_AGE: begin
            diff_in  = cur_ff.now - slot_rd.stamp;
            evh_in   = slot_rd.hnd;
            evlen_in = slot_rd.len;
            evq_in   = qbit_rd;
         end
         tw_pkg::BK_ADD_DECIDE: begin
            if (evict_ok) begin
               evv_in     = 1'b1;
               bytes_in   = bytes_ff - tw_pkg::BYTES_W'(evlen_ff);
               trail_in   = trail_ff + 32'd1;
               unl_idx_in = trail_idx;
               ret_add_in = 1'b1;
            end else begin
               evh_in    = '0;
               status_in = tw_pkg::ST_WINDOW_FULL;
            end
         end
         tw_pkg::BK_ADD_WRITE: begin
            slot_we  = 1'b1;
            qbit_we  = 1'b1;
            qbit_wa  = lead_idx_next;
            qbit_wd  = 1'b0;
            lead_in  = lead_ff + 32'd1;
            bytes_in = bytes_ff + tw_pkg::BYTES_W'(cur_ff.len);
            rseq_in  = lead_ff + 32'd1;
            rhnd_in  = cur_ff.hnd;
            rlen_in  = cur_ff.len;
         end
         tw_pkg::BK_FIND_CHECK: begin
            if (!inwin) begin
               status_in = tw_pkg::ST_NOT_IN_WINDOW;
            end
         end
         tw_pkg::BK_FIND_DONE: begin
            rseq_in = cur_ff.seq;
            rhnd_in = slot_rd.hnd;
            rlen_in = slot_rd.len;
            if (cur_ff.cmd == tw_pkg::CMD_NAK) begin
               if (qbit_rd) begin
                  status_in = tw_pkg::ST_ALREADY_QUEUED;
               end else begin
                  qbit_we = 1'b1;
                  qbit_wa = seq_idx;
                  qbit_wd = 1'b1;
                  if (!nonempty_ff) begin
                     oldest_in   = seq_idx;
                     newest_in   = seq_idx;
                     nonempty_in = 1'b1;
                     head_hnd_in = slot_rd.hnd;
                  end else begin
                     nxt_we    = 1'b1;
                     nxt_wa    = newest_ff;
                     nxt_wd    = seq_idx;
                     prv_we    = 1'b1;
                     prv_wa    = seq_idx;
                     prv_wd    = newest_ff;
                     newest_in = seq_idx;
                  end
               end
            end
         end
         tw_pkg::BK_POP_CHECK: begin
            if (!nonempty_ff) begin
               status_in = tw_pkg::ST_QUEUE_EMPTY;
            end else begin
               rseq_in    = trail_ff + 32'(head_off);
               rhnd_in    = head_hnd_ff;
               unl_idx_in = oldest_ff;
               ret_add_in = 1'b0;
            end
         end
         tw_pkg::BK_POP_READ: rlen_in = slot_rd.len;
         tw_pkg::BK_UNLINK_READ: ;
         tw_pkg::BK_UNLINK_LINK: begin
            qbit_we = 1'b1;
            if (is_old && is_new) begin
               nonempty_in = 1'b0;
            end else if (is_old) begin
               oldest_in = nxt_rd;
            end else if (is_new) begin
               newest_in = prv_rd;
            end else begin
               nxt_we = 1'b1;
               prv_we = 1'b1;
            end
         end
         tw_pkg::BK_UNLINK_HEAD: head_hnd_in = slot_rd.hnd;
         tw_pkg::BK_RESPOND: begin
            valid_in                = 1'b1;
            out_in.status           = status_ff;
            out_in.result_sequence  = rseq_ff;
            out_in.result_handle    = rhnd_ff;
            out_in.result_length    = rlen_ff;
            out_in.evicted_valid    = evv_ff;
            out_in.evicted_handle   = evh_ff;
            out_in.retx_pending     = nonempty_ff;
            out_in.retx_head_seq    = nonempty_ff ? trail_ff + 32'(head_off) : '0;
            out_in.retx_head_handle = nonempty_ff ? head_hnd_ff : '0;
            out_in.lead_seq         = lead_ff;
            out_in.trail_seq        = trail_ff;
            out_in.window_bytes     = bytes_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= tw_pkg::BK_IDLE;
         lead_ff     <= '1;
         trail_ff    <= '0;
         bytes_ff    <= '0;
         oldest_ff   <= '0;
         newest_ff   <= '0;
         nonempty_ff <= 1'b0;
         sec_ff      <= '0;
         thr_ff      <= tw_pkg::US_PER_SEC;
         valid_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         lead_ff     <= lead_in;
         trail_ff    <= trail_in;
         bytes_ff    <= bytes_in;
         oldest_ff   <= oldest_in;
         newest_ff   <= newest_in;
         nonempty_ff <= nonempty_in;
         valid_ff    <= valid_in;
         if (csr_wr_en) begin
            sec_ff <= csr_wr_data;
            thr_ff <= thr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      head_hnd_ff <= head_hnd_in;
      ret_add_ff  <= ret_add_in;
      unl_idx_ff  <= unl_idx_in;
      diff_ff     <= diff_in;
      evq_ff      <= evq_in;
      evlen_ff    <= evlen_in;
      status_ff   <= status_in;
      rseq_ff     <= rseq_in;
      rhnd_ff     <= rhnd_in;
      rlen_ff     <= rlen_in;
      evv_ff      <= evv_in;
      evh_ff      <= evh_in;
      out_ff      <= out_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = out_ff;

endmodule

[rtl/transmit_window_with_nak_queue.sv]
// ----------------------------------------------------------------------------
// transmit_window_with_nak_queue
// Sender retransmit window with a NAK retransmit queue.
//
// Channel     Ports            Handshake
// command     start/busy       accepted when start is high and busy is low
// result      rsp_valid        one-cycle strobe, always taken
// config      csr_wr_en        written on any edge with csr_wr_en high
//
// Each command takes its own path through the executor: lookup and NAK test the
// window and, when in it, read the slot; pop tests the queue, then reads and
// unlinks its head; add writes at once with room, else reads the oldest slot's age,
// rejects or evicts it, and unlinks the evicted entry first when it was queued.
// Each RAM access goes through the registered read port.
// A two-entry command queue lets busy stay low while the executor works.
// Reset is synchronous; no memory clearing pass is needed after it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module transmit_window_with_nak_queue #(
   parameter int WINDOW_SLOTS = tw_pkg::SLOTS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_command,
   input  logic [tw_pkg::SEQ_W-1:0]   req_sequence_req,
   input  logic [tw_pkg::HND_W-1:0]   req_packet_handle,
   input  logic [tw_pkg::LEN_W-1:0]   req_packet_length,
   input  logic [tw_pkg::STAMP_W-1:0] req_now_us,
   input  logic                       csr_wr_en,
   input  logic [tw_pkg::SEC_W-1:0]   csr_wr_data,
   output logic                       rsp_valid,
   output logic [2:0]                 rsp_status,
   output logic [tw_pkg::SEQ_W-1:0]   rsp_result_sequence,
   output logic [tw_pkg::HND_W-1:0]   rsp_result_handle,
   output logic [tw_pkg::LEN_W-1:0]   rsp_result_length,
   output logic                       rsp_evicted_valid,
   output logic [tw_pkg::HND_W-1:0]   rsp_evicted_handle,
   output logic                       rsp_retx_pending,
   output logic [tw_pkg::SEQ_W-1:0]   rsp_retx_head_seq,
   output logic [tw_pkg::HND_W-1:0]   rsp_retx_head_handle,
   output logic [tw_pkg::SEQ_W-1:0]   rsp_lead_seq,
   output logic [tw_pkg::SEQ_W-1:0]   rsp_trail_seq,
   output logic [tw_pkg::BYTES_W-1:0] rsp_window_bytes
);

   logic             item_valid, item_pop;
   tw_pkg::item_type item;
   tw_pkg::rsp_type  rsp;

   tw_front u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_sequence_req(req_sequence_req),
      .req_packet_handle(req_packet_handle), .req_packet_length(req_packet_length),
      .req_now_us(req_now_us), .item_valid(item_valid), .item(item),
      .item_pop(item_pop));

   tw_back #(.SLOTS(WINDOW_SLOTS)) u_back (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data), .item_valid(item_valid), .item(item),
      .item_pop(item_pop), .rsp_valid(rsp_valid), .rsp(rsp));

   assign rsp_status           = rsp.status;
   assign rsp_result_sequence  = rsp.result_sequence;
   assign rsp_result_handle    = rsp.result_handle;
   assign rsp_result_length    = rsp.result_length;
   assign rsp_evicted_valid    = rsp.evicted_valid;
   assign rsp_evicted_handle   = rsp.evicted_handle;
   assign rsp_retx_pending     = rsp.retx_pending;
   assign rsp_retx_head_seq    = rsp.retx_head_seq;
   assign rsp_retx_head_handle = rsp.retx_head_handle;
   assign rsp_lead_seq         = rsp.lead_seq;
   assign rsp_trail_seq        = rsp.trail_seq;
   assign rsp_window_bytes     = rsp.window_bytes;

   // A result strobe is never directly followed by another strobe.
   `ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid)
   // An empty retransmit queue reports a zero head.
   `ASSERT_SAME(a_empty_head, clock, reset, rsp_valid && !rsp_retx_pending,
                rsp_retx_head_seq == '0 && rsp_retx_head_handle == '0)
   // A rejected add never evicts.
   `ASSERT_SAME(a_reject_no_evict, clock, reset,
                rsp_valid && rsp_status == tw_pkg::ST_WINDOW_FULL, !rsp_evicted_valid)

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Transmit window with NAK queue: a random and directed command stream is
// driven through start/busy, every result strobe is checked field by field
// against an in-bench model of the window, the NAK queue and the byte sum.
// ----------------------------------------------------------------------------
module tb;

   localparam int NSLOT = 256;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic [1:0]                   req_command;
   logic [tw_pkg::SEQ_W-1:0]     req_sequence_req;
   logic [tw_pkg::HND_W-1:0]     req_packet_handle;
   logic [tw_pkg::LEN_W-1:0]     req_packet_length;
   logic [tw_pkg::STAMP_W-1:0]   req_now_us;
   logic                         csr_wr_en;
   logic [tw_pkg::SEC_W-1:0]     csr_wr_data;
   logic                         rsp_valid;
   logic [2:0]                   rsp_status;
   logic [tw_pkg::SEQ_W-1:0]     rsp_result_sequence;
   logic [tw_pkg::HND_W-1:0]     rsp_result_handle;
   logic [tw_pkg::LEN_W-1:0]     rsp_result_length;
   logic                         rsp_evicted_valid;
   logic [tw_pkg::HND_W-1:0]     rsp_evicted_handle;
   logic                         rsp_retx_pending;
   logic [tw_pkg::SEQ_W-1:0]     rsp_retx_head_seq;
   logic [tw_pkg::HND_W-1:0]     rsp_retx_head_handle;
   logic [tw_pkg::SEQ_W-1:0]     rsp_lead_seq;
   logic [tw_pkg::SEQ_W-1:0]     rsp_trail_seq;
   logic [tw_pkg::BYTES_W-1:0]   rsp_window_bytes;

   transmit_window_with_nak_queue u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_sequence_req(req_sequence_req),
      .req_packet_handle(req_packet_handle), .req_packet_length(req_packet_length),
      .req_now_us(req_now_us), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_result_sequence(rsp_result_sequence), .rsp_result_handle(rsp_result_handle),
      .rsp_result_length(rsp_result_length), .rsp_evicted_valid(rsp_evicted_valid),
      .rsp_evicted_handle(rsp_evicted_handle), .rsp_retx_pending(rsp_retx_pending),
      .rsp_retx_head_seq(rsp_retx_head_seq), .rsp_retx_head_handle(rsp_retx_head_handle),
      .rsp_lead_seq(rsp_lead_seq), .rsp_trail_seq(rsp_trail_seq),
      .rsp_window_bytes(rsp_window_bytes)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Model state of the window and the NAK queue.
   logic [tw_pkg::HND_W-1:0]   win_handle [NSLOT];
   logic [tw_pkg::LEN_W-1:0]   win_length [NSLOT];
   logic [tw_pkg::STAMP_W-1:0] win_stamp  [NSLOT];
   bit                         win_queued [NSLOT];
   logic [7:0]                 nak_next   [NSLOT];
   logic [7:0]                 nak_prev   [NSLOT];
   logic [7:0]                 nak_oldest, nak_newest;
   bit                         nak_nonempty;
   logic [tw_pkg::SEQ_W-1:0]   win_lead, win_trail;
   logic [tw_pkg::BYTES_W-1:0] win_bytes;
   logic [tw_pkg::SEC_W-1:0]   age_limit;

   tw_pkg::item_type pending_items [$];
   tw_pkg::rsp_type  expected_rsps [$];
   tw_pkg::item_type cur_item;
   int       n_accepted, n_checked, n_errors, n_evicted, n_full, n_popped;
   bit       no_idle;

   function automatic logic [tw_pkg::SEQ_W-1:0] seq_of_slot(logic [7:0] idx);
      return win_trail + tw_pkg::SEQ_W'(8'(idx - win_trail[7:0]));
   endfunction

   task automatic nak_unlink(logic [7:0] idx);
      win_queued[idx] = 0;
      if (idx == nak_oldest && idx == nak_newest) begin
         nak_nonempty = 0;
      end else if (idx == nak_oldest) begin
         nak_oldest = nak_next[idx];
      end else if (idx == nak_newest) begin
         nak_newest = nak_prev[idx];
      end else begin
         nak_next[nak_prev[idx]] = nak_next[idx];
         nak_prev[nak_next[idx]] = nak_prev[idx];
      end
   endtask

   task automatic nak_push(logic [7:0] idx);
      win_queued[idx] = 1;
      if (!nak_nonempty) begin
         nak_oldest = idx;
         nak_newest = idx;
         nak_nonempty = 1;
      end else begin
         nak_next[nak_newest] = idx;
         nak_prev[idx] = nak_newest;
         nak_newest = idx;
      end
   endtask

   task automatic predict_window(input tw_pkg::item_type it, output tw_pkg::rsp_type r);
      logic [tw_pkg::SEQ_W-1:0]   held;
      logic [7:0]                 idx;
      logic [tw_pkg::STAMP_W-1:0] age;
      bit                         ok;
      r = '0;
      r.status = tw_pkg::ST_OK;
      held = win_lead + 1 - win_trail;
      case (it.cmd)
         tw_pkg::CMD_ADD: begin
            ok = 1;
            if (held >= NSLOT) begin
               idx = win_trail[7:0];
               age = (it.now - win_stamp[idx]) / 48'd1000000;
               if (age_limit == 0 || age > tw_pkg::STAMP_W'(age_limit)) begin
                  if (win_queued[idx]) nak_unlink(idx);
                  win_bytes = win_bytes - tw_pkg::BYTES_W'(win_length[idx]);
                  r.evicted_valid = 1;
                  r.evicted_handle = win_handle[idx];
                  win_trail = win_trail + 1;
               end else begin
                  ok = 0;
               end
            end
            if (ok) begin
               win_lead = win_lead + 1;
               idx = win_lead[7:0];
               win_handle[idx] = it.hnd;
               win_length[idx] = it.len;
               win_stamp[idx] = it.now;
               win_queued[idx] = 0;
               win_bytes = win_bytes + tw_pkg::BYTES_W'(it.len);
               r.result_sequence = win_lead;
               r.result_handle = it.hnd;
               r.result_length = it.len;
            end else begin
               r.status = tw_pkg::ST_WINDOW_FULL;
            end
         end
         tw_pkg::CMD_LOOKUP, tw_pkg::CMD_NAK: begin
            if (it.seq - win_trail >= held) begin
               r.status = tw_pkg::ST_NOT_IN_WINDOW;
            end else begin
               idx = it.seq[7:0];
               r.result_sequence = it.seq;
               r.result_handle = win_handle[idx];
               r.result_length = win_length[idx];
               if (it.cmd == tw_pkg::CMD_NAK) begin
                  if (win_queued[idx]) r.status = tw_pkg::ST_ALREADY_QUEUED;
                  else nak_push(idx);
               end
            end
         end
         default: begin
            if (!nak_nonempty) begin
               r.status = tw_pkg::ST_QUEUE_EMPTY;
            end else begin
               idx = nak_oldest;
               r.result_sequence = seq_of_slot(idx);
               r.result_handle = win_handle[idx];
               r.result_length = win_length[idx];
               nak_unlink(idx);
            end
         end
      endcase
      r.retx_pending = nak_nonempty;
      if (nak_nonempty) begin
         r.retx_head_seq = seq_of_slot(nak_oldest);
         r.retx_head_handle = win_handle[nak_oldest];
      end
      r.lead_seq = win_lead;
      r.trail_seq = win_trail;
      r.window_bytes = win_bytes;
   endtask

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      n_errors++;
      $display("mismatch at result %0d: %s got 0x%0h, expected 0x%0h",
               n_checked, field, got, want);
   endtask

   // Driver: a new transaction is offered once the previous one is taken.
   always @(posedge clock) begin : driver
      tw_pkg::rsp_type r;
      bit      go;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predict_window(cur_item, r);
            expected_rsps.push_back(r);
            if (r.evicted_valid) n_evicted++;
            if (r.status == tw_pkg::ST_WINDOW_FULL) n_full++;
            if (cur_item.cmd == tw_pkg::CMD_POP && r.status == tw_pkg::ST_OK) n_popped++;
            n_accepted++;
         end
         if (!start || !busy) begin
            go = pending_items.size() > 0 && (no_idle || $urandom_range(99) >= 18);
            if (go) begin
               cur_item = pending_items.pop_front();
               req_command       <= cur_item.cmd;
               req_sequence_req  <= cur_item.seq;
               req_packet_handle <= cur_item.hnd;
               req_packet_length <= cur_item.len;
               req_now_us        <= cur_item.now;
            end
            start <= go;
         end
      end
   end

   // Monitor: every strobe is taken and checked against the oldest expectation.
   always @(posedge clock) begin : monitor
      tw_pkg::rsp_type e;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected strobe", 64'(rsp_status), 64'd0);
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_status != e.status) report_mismatch("status", rsp_status, e.status);
            if (rsp_result_sequence != e.result_sequence)
               report_mismatch("result_sequence", rsp_result_sequence, e.result_sequence);
            if (rsp_result_handle != e.result_handle)
               report_mismatch("result_handle", rsp_result_handle, e.result_handle);
            if (rsp_result_length != e.result_length)
               report_mismatch("result_length", rsp_result_length, e.result_length);
            if (rsp_evicted_valid != e.evicted_valid)
               report_mismatch("evicted_valid", rsp_evicted_valid, e.evicted_valid);
            if (rsp_evicted_handle != e.evicted_handle)
               report_mismatch("evicted_handle", rsp_evicted_handle, e.evicted_handle);
            if (rsp_retx_pending != e.retx_pending)
               report_mismatch("retx_pending", rsp_retx_pending, e.retx_pending);
            if (rsp_retx_head_seq != e.retx_head_seq)
               report_mismatch("retx_head_seq", rsp_retx_head_seq, e.retx_head_seq);
            if (rsp_retx_head_handle != e.retx_head_handle)
               report_mismatch("retx_head_handle", rsp_retx_head_handle, e.retx_head_handle);
            if (rsp_lead_seq != e.lead_seq)
               report_mismatch("lead_seq", rsp_lead_seq, e.lead_seq);
            if (rsp_trail_seq != e.trail_seq)
               report_mismatch("trail_seq", rsp_trail_seq, e.trail_seq);
            if (rsp_window_bytes != e.window_bytes)
               report_mismatch("window_bytes", rsp_window_bytes, e.window_bytes);
            n_checked++;
         end
      end
   end

   // Generator side: a rough idea of the newest sequence steers lookups and NAKs
   // toward the window; rejected adds make it drift, which only adds variety.
   logic [tw_pkg::SEQ_W-1:0]   gen_lead;
   logic [tw_pkg::STAMP_W-1:0] gen_now;

   task automatic queue_item(tw_pkg::cmd_type c, logic [tw_pkg::SEQ_W-1:0] s,
                             logic [tw_pkg::HND_W-1:0] h, logic [tw_pkg::LEN_W-1:0] l);
      tw_pkg::item_type it;
      it.cmd = c;
      it.seq = s;
      it.hnd = h;
      it.len = l;
      it.now = gen_now;
      if (c == tw_pkg::CMD_ADD) gen_lead = gen_lead + 1;
      pending_items.push_back(it);
   endtask

   task automatic queue_random(int n, int jump_sec);
      int                       k;
      logic [tw_pkg::SEQ_W-1:0] s;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         // Time mostly creeps forward; now and then it leaps or goes wild.
         if ($urandom_range(99) < 3)
            gen_now = gen_now + 48'(jump_sec) * 48'd1000000 + 48'($urandom_range(2000000));
         else if ($urandom_range(199) == 0)
            gen_now = 48'({$urandom, $urandom});
         else
            gen_now = gen_now + 48'($urandom_range(40000));
         if ($urandom_range(9) == 0) s = $urandom;
         else s = gen_lead - $urandom_range(270);
         if (k < 45)
            queue_item(tw_pkg::CMD_ADD, $urandom, 16'($urandom), 16'($urandom));
         else if (k < 60)
            queue_item(tw_pkg::CMD_LOOKUP, s, 16'($urandom), 16'($urandom));
         else if (k < 82)
            queue_item(tw_pkg::CMD_NAK, s, 16'($urandom), 16'($urandom));
         else
            queue_item(tw_pkg::CMD_POP, $urandom, 16'($urandom), 16'($urandom));
      end
   endtask

   task automatic drain_and_set(logic [tw_pkg::SEC_W-1:0] secs);
      while (pending_items.size() > 0 || start || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= secs;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      age_limit = secs;
   endtask

   initial begin : stimulus
      reset = 1'b1;
      start = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_command = tw_pkg::CMD_ADD;
      req_sequence_req = '0;
      req_packet_handle = '0;
      req_packet_length = '0;
      req_now_us = '0;
      no_idle = 0;
      n_accepted = 0; n_checked = 0; n_errors = 0;
      n_evicted = 0; n_full = 0; n_popped = 0;
      foreach (win_queued[i]) win_queued[i] = 0;
      nak_oldest = 0; nak_newest = 0; nak_nonempty = 0;
      win_lead = '1; win_trail = '0; win_bytes = '0; age_limit = '0;
      gen_lead = '1;
      // Start close to the top of the time stamp range so that it wraps early.
      gen_now = {tw_pkg::STAMP_W{1'b1}} - 48'd3000000;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      drain_and_set(12'd0);
      // Directed: empty window and empty queue, field extremes, double NAK.
      queue_item(tw_pkg::CMD_POP, '1, '1, '1);
      queue_item(tw_pkg::CMD_LOOKUP, '0, '0, '0);
      queue_item(tw_pkg::CMD_NAK, '1, '0, '0);
      queue_item(tw_pkg::CMD_ADD, '1, 16'hffff, 16'hffff);
      queue_item(tw_pkg::CMD_ADD, '0, 16'h0000, 16'h0000);
      queue_item(tw_pkg::CMD_ADD, '0, 16'h5a5a, 16'h1234);
      queue_item(tw_pkg::CMD_LOOKUP, 32'd0, '0, '0);
      queue_item(tw_pkg::CMD_LOOKUP, 32'd3, '0, '0);
      queue_item(tw_pkg::CMD_NAK, 32'd1, '0, '0);
      queue_item(tw_pkg::CMD_NAK, 32'd1, '0, '0);
      queue_item(tw_pkg::CMD_NAK, 32'd0, '0, '0);
      queue_item(tw_pkg::CMD_NAK, 32'd2, '0, '0);
      queue_item(tw_pkg::CMD_POP, '0, '0, '0);
      gen_now = gen_now + 48'd5000000;
      queue_item(tw_pkg::CMD_ADD, '0, 16'h8000, 16'h0001);
      queue_item(tw_pkg::CMD_POP, '0, '0, '0);
      queue_item(tw_pkg::CMD_POP, '0, '0, '0);
      queue_item(tw_pkg::CMD_POP, '0, '0, '0);
      queue_item(tw_pkg::CMD_NAK, 32'hffff_ffff, '0, '0);
      // Fill the ring so that later adds hit the full case, with queued NAKs.
      for (int i = 0; i < 260; i++) begin
         gen_now = gen_now + 48'($urandom_range(20000));
         queue_item(tw_pkg::CMD_ADD, '0, 16'($urandom), 16'($urandom));
         if (i % 16 == 0) queue_item(tw_pkg::CMD_NAK, gen_lead - 2, '0, '0);
      end
      queue_random(120, 1);
      no_idle = 1;
      queue_random(150, 1);
      drain_and_set(12'd4095);
      no_idle = 0;
      queue_random(200, 5000);
      drain_and_set(12'd1);
      queue_random(200, 2);
      drain_and_set(12'd3600);
      queue_random(150, 3601);
      drain_and_set(12'd0);
      queue_random(150, 1);

      while (pending_items.size() > 0 || start || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
      $display("%0d commands checked over five age limits (0 to 4095 s)", n_checked);
      $display("%0d evictions, %0d full rejections, %0d NAKs served",
               n_evicted, n_full, n_popped);
      if (n_errors == 0 && expected_rsps.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
